>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define REM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define REM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rem_pkg.sv
// Types and constants of the row-end mode detector.
package rem_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROUND_Z_LOW    = 3'd0,
      CSR_GROUND_Z_HIGH   = 3'd1,
      CSR_END_RATIO_PCT   = 3'd2,
      CSR_START_RATIO_PCT = 3'd3,
      CSR_COUNT_LIMIT     = 3'd4
   } csr_idx_type;

   localparam logic signed [15:0] GROUND_Z_LOW_RST    = -16'sd375;
   localparam logic signed [15:0] GROUND_Z_HIGH_RST   = -16'sd365;
   localparam logic [6:0]         END_RATIO_PCT_RST   = 7'd20;
   localparam logic [6:0]         START_RATIO_PCT_RST = 7'd75;
   localparam logic [7:0]         COUNT_LIMIT_RST     = 8'd20;

   localparam logic [6:0]         PCT_SCALE  = 7'd100;
   localparam logic [7:0]         MODE_CNT_MAX = 8'hFF;
   localparam logic [15:0]        OUT_MAX    = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] ground_z_low;
      logic signed [15:0] ground_z_high;
      logic [6:0]         end_ratio_pct;
      logic [6:0]         start_ratio_pct;
      logic [7:0]         count_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_z;
      logic               frame_last;
   } pt_type;

   typedef struct packed {
      logic        turning_mode;
      logic [15:0] valid_points;
      logic [15:0] ahead_points;
   } rsp_type;

endpackage

>>> rtl/rem_ifs.sv
// Channel interfaces: point input, frame result and register write.
interface rem_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_z;
   logic               frame_last;

   modport source (output valid, point_x, point_z, frame_last, input ready);
   modport sink (input valid, point_x, point_z, frame_last, output ready);
endinterface

interface rem_rsp_if;
   logic        valid;
   logic        ready;
   logic        turning_mode;
   logic [15:0] valid_points;
   logic [15:0] ahead_points;

   modport source (output valid, turning_mode, valid_points, ahead_points, input ready);
   modport sink (input valid, turning_mode, valid_points, ahead_points, output ready);
endinterface

interface rem_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rem_cfg_regs.sv
// Configuration register file.
module rem_cfg_regs
   import rem_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   rem_csr_if.sink csr,
   output cfg_type cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;

   assign csr.ready = 1'b1;
   assign idx       = csr_idx_type'(csr.index);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (idx)
            CSR_GROUND_Z_LOW:    cfg_in.ground_z_low    = csr.data;
            CSR_GROUND_Z_HIGH:   cfg_in.ground_z_high   = csr.data;
            CSR_END_RATIO_PCT:   cfg_in.end_ratio_pct   = csr.data[6:0];
            CSR_START_RATIO_PCT: cfg_in.start_ratio_pct = csr.data[6:0];
            CSR_COUNT_LIMIT:     cfg_in.count_limit     = csr.data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_z_low    <= GROUND_Z_LOW_RST;
         cfg_ff.ground_z_high   <= GROUND_Z_HIGH_RST;
         cfg_ff.end_ratio_pct   <= END_RATIO_PCT_RST;
         cfg_ff.start_ratio_pct <= START_RATIO_PCT_RST;
         cfg_ff.count_limit     <= COUNT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/rem_point_stage.sv
// Input register for point beats.
module rem_point_stage
   import rem_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   rem_req_if.sink req,
   output logic    pt_valid,
   output pt_type  pt,
   input  logic    pt_take
);

   logic   valid_ff;
   logic   valid_in;
   pt_type pt_ff;
   logic   accept;

   assign req.ready = !valid_ff || pt_take;
   assign accept    = req.valid && req.ready;
   assign valid_in  = accept || (valid_ff && !pt_take);
   assign pt_valid  = valid_ff;
   assign pt        = pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pt_ff.point_x    <= req.point_x;
         pt_ff.point_z    <= req.point_z;
         pt_ff.frame_last <= req.frame_last;
      end
   end

endmodule

>>> rtl/rem_frame_core.sv
// Point classification, frame tallies, mode counters and result register.
module rem_frame_core
   import rem_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    pt_valid,
   input  pt_type  pt,
   output logic    pt_take,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned PW = COUNT_WIDTH + 7;
   localparam int unsigned OW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   logic [COUNT_WIDTH-1:0] valid_tally_ff, valid_tally_in, valid_nx;
   logic [COUNT_WIDTH-1:0] ahead_tally_ff, ahead_tally_in, ahead_nx;
   logic                   turning_ff, turning_in, turning_eval;
   logic [7:0]             end_cnt_ff, end_cnt_in, end_eval, end_bumped;
   logic [7:0]             start_cnt_ff, start_cnt_in, start_eval, start_bumped;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   logic                   is_ground, is_valid, is_ahead;
   logic                   frame_done, any_valid;
   logic [PW-1:0]          ahead100, end_prod, start_prod;
   logic [OW-1:0]          valid_ext, ahead_ext;
   logic [15:0]            valid_out, ahead_out;

   assign is_ground = (pt.point_z > cfg.ground_z_low) && (pt.point_z < cfg.ground_z_high);
   assign is_valid  = !is_ground;
   assign is_ahead  = is_valid && (pt.point_x > 16'sd0);

   assign valid_nx = (is_valid && (valid_tally_ff != '1)) ?
                     valid_tally_ff + 1'b1 : valid_tally_ff;
   assign ahead_nx = (is_ahead && (ahead_tally_ff != '1)) ?
                     ahead_tally_ff + 1'b1 : ahead_tally_ff;

   assign pt_take    = pt_valid && (!pt.frame_last || !rsp_valid_ff || rsp_ready);
   assign frame_done = pt_take && pt.frame_last;

   assign ahead100   = PW'(ahead_nx) * PW'(PCT_SCALE);
   assign end_prod   = PW'(cfg.end_ratio_pct) * PW'(valid_nx);
   assign start_prod = PW'(cfg.start_ratio_pct) * PW'(valid_nx);
   assign any_valid  = (valid_nx != '0);

   assign end_bumped = (any_valid && (ahead100 < end_prod) && (end_cnt_ff != MODE_CNT_MAX)) ?
                       end_cnt_ff + 8'd1 : end_cnt_ff;
   assign start_bumped = (any_valid && (ahead100 > start_prod) &&
                          (start_cnt_ff != MODE_CNT_MAX)) ?
                         start_cnt_ff + 8'd1 : start_cnt_ff;

   always_comb begin
      turning_eval = turning_ff;
      end_eval     = end_cnt_ff;
      start_eval   = start_cnt_ff;
      if (!turning_ff) begin
         if (end_bumped > cfg.count_limit) begin
            turning_eval = 1'b1;
            end_eval     = 8'd0;
         end else begin
            end_eval = end_bumped;
         end
      end else begin
         if (start_bumped > cfg.count_limit) begin
            turning_eval = 1'b0;
            start_eval   = 8'd0;
         end else begin
            start_eval = start_bumped;
         end
      end
   end

   assign valid_ext = OW'(valid_nx);
   assign ahead_ext = OW'(ahead_nx);
   assign valid_out = (valid_ext > OW'(OUT_MAX)) ? OUT_MAX : valid_ext[15:0];
   assign ahead_out = (ahead_ext > OW'(OUT_MAX)) ? OUT_MAX : ahead_ext[15:0];

   always_comb begin
      valid_tally_in = valid_tally_ff;
      ahead_tally_in = ahead_tally_ff;
      turning_in     = turning_ff;
      end_cnt_in     = end_cnt_ff;
      start_cnt_in   = start_cnt_ff;
      if (pt_take) begin
         if (pt.frame_last) begin
            valid_tally_in = '0;
            ahead_tally_in = '0;
            turning_in     = turning_eval;
            end_cnt_in     = end_eval;
            start_cnt_in   = start_eval;
         end else begin
            valid_tally_in = valid_nx;
            ahead_tally_in = ahead_nx;
         end
      end
   end

   assign rsp_valid_in = frame_done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_tally_ff <= '0;
         ahead_tally_ff <= '0;
         turning_ff     <= 1'b0;
         end_cnt_ff     <= 8'd0;
         start_cnt_ff   <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_tally_ff <= valid_tally_in;
         ahead_tally_ff <= ahead_tally_in;
         turning_ff     <= turning_in;
         end_cnt_ff     <= end_cnt_in;
         start_cnt_ff   <= start_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_ff.turning_mode <= turning_eval;
         rsp_ff.valid_points <= valid_out;
         rsp_ff.ahead_points <= ahead_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/row_end_mode_detector_top.sv
// Row-end mode detector top level.
// Points enter on req_bus, one per beat: point_x, point_z (signed mm) and
// frame_last on the final point of a scan frame. Non-ground points are
// tallied; the frame_last beat closes the frame and yields one beat on
// rsp_bus with the mode after that frame and the frame's saturated tallies.
// Registers must be written by the user on csr_bus (index, data) only while
// no point is in flight; the block does not enforce it. A point lands in
// the input register at its accepting edge; the frame result is registered
// when its frame_last point is taken. Throughput: one point per cycle, but
// for the stall below, set by the single input register feeding the tally
// and compare logic. A stalled rsp_bus holds its beat; points keep flowing
// until a second frame_last reaches the input register, which then holds
// and drops req_bus.ready until the pending result is taken.
// Reset clears tallies, mode (driving), both mode counters and all valid
// flags, and loads the register defaults.
module row_end_mode_detector_top
   import rem_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   rem_req_if.sink     req_bus,
   rem_rsp_if.source   rsp_bus,
   rem_csr_if.sink     csr_bus
);

   cfg_type cfg;
   pt_type  pt;
   logic    pt_valid;
   logic    pt_take;
   rsp_type rsp_data;
   logic    rsp_valid;

   rem_cfg_regs u_cfg (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   rem_point_stage u_pt (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .pt_valid (pt_valid),
      .pt       (pt),
      .pt_take  (pt_take)
   );

   rem_frame_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pt_valid  (pt_valid),
      .pt        (pt),
      .pt_take   (pt_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.turning_mode = rsp_data.turning_mode;
   assign rsp_bus.valid_points = rsp_data.valid_points;
   assign rsp_bus.ahead_points = rsp_data.ahead_points;

endmodule

>>> rtl/rem_checker.sv
// Port-level checks for the row-end mode detector, bound to the top level.
`include "assert_macros.svh"

module rem_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        turning_mode,
   input logic [15:0] valid_points,
   input logic [15:0] ahead_points
);

   `REM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
   `REM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(turning_mode) && $stable(valid_points) && $stable(ahead_points), "rsp payload changed while stalled")
   `REM_ASSERT_NOW(a_ahead_le_valid, clock, reset, rsp_valid, ahead_points <= valid_points, "ahead count exceeds valid count")
   `REM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind row_end_mode_detector_top rem_checker u_rem_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .turning_mode (rsp_bus.turning_mode),
   .valid_points (rsp_bus.valid_points),
   .ahead_points (rsp_bus.ahead_points)
);
